/* src/three_plane_linear_solve_unit_macros.svh */
// assertion macros shared by the plane solve unit
`ifndef THREE_PLANE_LINEAR_SOLVE_UNIT_MACROS_SVH
`define THREE_PLANE_LINEAR_SOLVE_UNIT_MACROS_SVH

// same-cycle implication on clk, off while arst_n is low
`define TPLS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpls: implication check failed");

// fixed-delay implication on clk, off while arst_n is low
`define TPLS_ASSERT_DLY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("tpls: delayed check failed");

`endif

/* src/tpls_pkg.sv */
// types, widths and latency figures of the plane solve unit
`timescale 1ns / 1ps

package tpls_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int COF_WIDTH   = 2 * DATA_WIDTH + 1;
	localparam int HI_WIDTH    = COF_WIDTH - DATA_WIDTH;
	localparam int PART_WIDTH  = 2 * DATA_WIDTH + 1;
	localparam int PROD_WIDTH  = DATA_WIDTH + COF_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 2;
	localparam int SHIFT_WIDTH = SUM_WIDTH + FRAC_BITS;
	localparam int UPPER_WIDTH = SHIFT_WIDTH - DATA_WIDTH;
	localparam int LANE_DEPTH  = DATA_WIDTH + 2;
	localparam int LATENCY     = LANE_DEPTH + 7;

	typedef logic signed [DATA_WIDTH-1:0]   data_t;
	typedef logic signed [2*DATA_WIDTH-1:0] pair_t;
	typedef logic signed [COF_WIDTH-1:0]    cof_t;
	typedef logic signed [PART_WIDTH-1:0]   part_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;
	typedef logic signed [SUM_WIDTH-1:0]    sum_t;
	typedef logic        [SUM_WIDTH-1:0]    mag_t;
	typedef logic        [SHIFT_WIDTH-1:0]  shift_t;

	typedef struct packed {
		data_t plane1_normal_x;
		data_t plane1_normal_y;
		data_t plane1_normal_z;
		data_t plane1_offset;
		data_t plane2_normal_x;
		data_t plane2_normal_y;
		data_t plane2_normal_z;
		data_t plane2_offset;
		data_t plane3_normal_x;
		data_t plane3_normal_y;
		data_t plane3_normal_z;
		data_t plane3_offset;
	} solve_in_t;

	typedef struct packed {
		data_t point_x;
		data_t point_y;
		data_t point_z;
		logic  singular;
	} solve_out_t;

	// one coordinate's division job
	typedef struct packed {
		mag_t num_mag;
		mag_t det_mag;
		logic neg;
		logic singular;
	} lane_in_t;

	typedef struct packed {
		data_t coord;
		logic  singular;
	} lane_out_t;

endpackage

/* src/tpls_cofactor.sv */
// 2x2 minors and signed cofactors of the normal matrix, two stages
`timescale 1ns / 1ps

module tpls_cofactor (
	input  logic                clk,
	input  tpls_pkg::solve_in_t operands,
	output tpls_pkg::cof_t      cof_s2 [3][3],
	output tpls_pkg::data_t     row0_s2 [3],
	output tpls_pkg::data_t     offs_s2 [3]
);

	tpls_pkg::data_t a [3][3];
	tpls_pkg::data_t d [3];
	tpls_pkg::data_t row0_s1 [3];
	tpls_pkg::data_t offs_s1 [3];

	// unpack the word into matrix rows and offsets
	always_comb begin
		a[0][0] = operands.plane1_normal_x;
		a[0][1] = operands.plane1_normal_y;
		a[0][2] = operands.plane1_normal_z;
		a[1][0] = operands.plane2_normal_x;
		a[1][1] = operands.plane2_normal_y;
		a[1][2] = operands.plane2_normal_z;
		a[2][0] = operands.plane3_normal_x;
		a[2][1] = operands.plane3_normal_y;
		a[2][2] = operands.plane3_normal_z;
		d[0]    = operands.plane1_offset;
		d[1]    = operands.plane2_offset;
		d[2]    = operands.plane3_offset;
	end

	// carry the first row and the offsets alongside
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			row0_s1[i] <= a[0][i];
			offs_s1[i] <= d[i];
			row0_s2[i] <= row0_s1[i];
			offs_s2[i] <= offs_s1[i];
		end
	end

	// one cross-product pair per matrix entry
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			localparam int R0 = (r == 0) ? 1 : 0;
			localparam int R1 = (r == 2) ? 1 : 2;
			localparam int K0 = (k == 0) ? 1 : 0;
			localparam int K1 = (k == 2) ? 1 : 2;
			localparam bit ODD = ((r + k) % 2) == 1;

			tpls_pkg::pair_t pa_s1;
			tpls_pkg::pair_t pb_s1;

			always_ff @(posedge clk) begin
				pa_s1 <= a[R0][K0] * a[R1][K1];
				pb_s1 <= a[R0][K1] * a[R1][K0];
			end

			// odd positions take the minor with its sign flipped
			always_ff @(posedge clk) begin
				if (ODD) begin
					cof_s2[r][k] <= tpls_pkg::cof_t'(pb_s1) - tpls_pkg::cof_t'(pa_s1);
				end else begin
					cof_s2[r][k] <= tpls_pkg::cof_t'(pa_s1) - tpls_pkg::cof_t'(pb_s1);
				end
			end
		end
	end

endmodule

/* src/tpls_accum.sv */
// determinant and adjugate numerators, split products, sums and magnitudes
`timescale 1ns / 1ps

module tpls_accum (
	input  logic               clk,
	input  tpls_pkg::cof_t     cof_s2 [3][3],
	input  tpls_pkg::data_t    row0_s2 [3],
	input  tpls_pkg::data_t    offs_s2 [3],
	output tpls_pkg::lane_in_t lane_s6 [3]
);

	localparam int NPROD = 12;

	tpls_pkg::data_t mx [NPROD];
	tpls_pkg::cof_t  mc [NPROD];
	tpls_pkg::part_t plo_s3 [NPROD];
	tpls_pkg::part_t phi_s3 [NPROD];
	tpls_pkg::prod_t prod_s4 [NPROD];
	tpls_pkg::sum_t  sum_s5 [4];
	tpls_pkg::mag_t  det_mag;

	// product list: three determinant terms, then three per coordinate
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mx[j] = row0_s2[j];
			mc[j] = cof_s2[0][j];
		end
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				mx[3 + 3 * i + k] = offs_s2[k];
				mc[3 + 3 * i + k] = cof_s2[k][i];
			end
		end
	end

	// split each wide product into low and high partials
	always_ff @(posedge clk) begin
		for (int j = 0; j < NPROD; j++) begin
			plo_s3[j] <= mx[j] * $signed({1'b0, mc[j][tpls_pkg::DATA_WIDTH-1:0]});
			phi_s3[j] <= mx[j] *
				$signed(mc[j][tpls_pkg::COF_WIDTH-1:tpls_pkg::DATA_WIDTH]);
		end
	end

	// recombine the partials
	always_ff @(posedge clk) begin
		for (int j = 0; j < NPROD; j++) begin
			prod_s4[j] <= (tpls_pkg::prod_t'(phi_s3[j]) <<< tpls_pkg::DATA_WIDTH) +
				tpls_pkg::prod_t'(plo_s3[j]);
		end
	end

	// three-term sums: determinant then the numerators
	always_ff @(posedge clk) begin
		for (int s = 0; s < 4; s++) begin
			sum_s5[s] <= tpls_pkg::sum_t'(prod_s4[3 * s]) +
				tpls_pkg::sum_t'(prod_s4[3 * s + 1]) +
				tpls_pkg::sum_t'(prod_s4[3 * s + 2]);
		end
	end

	// determinant magnitude is shared by all lanes
	always_comb begin
		det_mag = sum_s5[0][tpls_pkg::SUM_WIDTH-1] ? tpls_pkg::mag_t'(-sum_s5[0]) :
			tpls_pkg::mag_t'(sum_s5[0]);
	end

	// magnitudes, quotient sign and singular flag per lane
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			lane_s6[i].num_mag  <= sum_s5[i + 1][tpls_pkg::SUM_WIDTH-1] ?
				tpls_pkg::mag_t'(-sum_s5[i + 1]) : tpls_pkg::mag_t'(sum_s5[i + 1]);
			lane_s6[i].det_mag  <= det_mag;
			lane_s6[i].neg      <= sum_s5[i + 1][tpls_pkg::SUM_WIDTH-1] ^
				sum_s5[0][tpls_pkg::SUM_WIDTH-1];
			lane_s6[i].singular <= (sum_s5[0] == '0);
		end
	end

endmodule

/* src/tpls_div_lane.sv */
// one coordinate lane: pipelined restoring divider with saturation
`timescale 1ns / 1ps

module tpls_div_lane (
	input  logic                clk,
	input  tpls_pkg::lane_in_t  lane_in,
	output tpls_pkg::lane_out_t lane_out
);

	localparam int DW = tpls_pkg::DATA_WIDTH;
	localparam int SW = tpls_pkg::SUM_WIDTH;

	tpls_pkg::shift_t               nsh;
	logic [tpls_pkg::UPPER_WIDTH-1:0] upper;
	logic                           ovf;

	tpls_pkg::mag_t rem_s  [0:DW];
	tpls_pkg::mag_t den_s  [0:DW];
	logic [DW-1:0]  low_s  [0:DW];
	logic [DW-1:0]  quo_s  [0:DW];
	logic           neg_s  [0:DW];
	logic           sing_s [0:DW];
	logic           ovf_s  [0:DW];

	logic [DW-1:0]  lim;
	logic [DW-1:0]  mag;
	logic           sat;

	// scale the numerator; its upper part seeds the remainder
	always_comb begin
		nsh   = tpls_pkg::shift_t'(lane_in.num_mag) << tpls_pkg::FRAC_BITS;
		upper = nsh[tpls_pkg::SHIFT_WIDTH-1:DW];
		ovf   = tpls_pkg::mag_t'(upper) >= lane_in.det_mag;
	end

	// entry stage
	always_ff @(posedge clk) begin
		rem_s[0]  <= tpls_pkg::mag_t'(upper);
		den_s[0]  <= lane_in.det_mag;
		low_s[0]  <= nsh[DW-1:0];
		quo_s[0]  <= '0;
		neg_s[0]  <= lane_in.neg;
		sing_s[0] <= lane_in.singular;
		ovf_s[0]  <= ovf;
	end

	// one quotient bit per stage
	for (genvar i = 1; i <= DW; i++) begin : g_step
		logic [SW:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[i-1], low_s[i-1][DW-1]};
			ge    = trial >= {1'b0, den_s[i-1]};
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? tpls_pkg::mag_t'(trial - {1'b0, den_s[i-1]}) :
				tpls_pkg::mag_t'(trial);
			quo_s[i]  <= {quo_s[i-1][DW-2:0], ge};
			low_s[i]  <= {low_s[i-1][DW-2:0], 1'b0};
			den_s[i]  <= den_s[i-1];
			neg_s[i]  <= neg_s[i-1];
			sing_s[i] <= sing_s[i-1];
			ovf_s[i]  <= ovf_s[i-1];
		end
	end

	// clamp to the signed range, limit depends on the sign
	always_comb begin
		lim = {neg_s[DW], {(DW-1){~neg_s[DW]}}};
		sat = ovf_s[DW] || (quo_s[DW] > lim);
		mag = sat ? lim : quo_s[DW];
	end

	// apply sign, zero on a singular system
	always_ff @(posedge clk) begin
		lane_out.coord    <= sing_s[DW] ? '0 :
			(neg_s[DW] ? tpls_pkg::data_t'(-mag) : tpls_pkg::data_t'(mag));
		lane_out.singular <= sing_s[DW];
	end

endmodule

/* src/three_plane_linear_solve_unit.sv */
// top level of the three-plane intersection solver
`timescale 1ns / 1ps
// Three-plane intersection solver.
// Input channel: start with operands (three normals and offsets, Q16.16).
// A word is taken at every rising edge where start is high and busy is low;
// busy never rises, so a new word may be issued on every cycle.
// Output channel: done marks result for exactly one cycle; the receiver
// has no way to stall it and must take the word in that cycle.
// From acceptance to done a word passes two cofactor stages, four
// product and sum stages, an entry stage, one stage per quotient bit
// in each divider lane, the sign and output register behind the
// combinational clamp and the merge register. Throughput is one word per
// cycle, set by the three divider lanes which are fully pipelined.
// A zero determinant gives singular high and a zero point.
// Reset clears the in-flight markers: words in the pipe at reset are dropped
// and no done follows them.
`include "three_plane_linear_solve_unit_macros.svh"

module three_plane_linear_solve_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tpls_pkg::solve_in_t  operands,
	output logic                 done,
	output tpls_pkg::solve_out_t result
);

	localparam int LAT = tpls_pkg::LATENCY;

	tpls_pkg::cof_t      cof_s2 [3][3];
	tpls_pkg::data_t     row0_s2 [3];
	tpls_pkg::data_t     offs_s2 [3];
	tpls_pkg::lane_in_t  lane_s6 [3];
	tpls_pkg::lane_out_t lane_out [3];
	logic [LAT-1:0]      vld_q;
	tpls_pkg::solve_out_t result_q;

	assign busy = 1'b0;

	tpls_cofactor u_cofactor (
		.clk     (clk),
		.operands(operands),
		.cof_s2  (cof_s2),
		.row0_s2 (row0_s2),
		.offs_s2 (offs_s2)
	);

	tpls_accum u_accum (
		.clk    (clk),
		.cof_s2 (cof_s2),
		.row0_s2(row0_s2),
		.offs_s2(offs_s2),
		.lane_s6(lane_s6)
	);

	// one divider lane per coordinate
	for (genvar i = 0; i < 3; i++) begin : g_lane
		tpls_div_lane u_lane (
			.clk     (clk),
			.lane_in (lane_s6[i]),
			.lane_out(lane_out[i])
		);
	end

	// in-flight markers follow each word down the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	// merge the lanes into the result word
	always_ff @(posedge clk) begin
		if (vld_q[LAT-2]) begin
			result_q.point_x  <= lane_out[0].coord;
			result_q.point_y  <= lane_out[1].coord;
			result_q.point_z  <= lane_out[2].coord;
			result_q.singular <= lane_out[0].singular;
		end
	end

	assign done   = vld_q[LAT-1];
	assign result = result_q;

	`TPLS_ASSERT_DLY(a_done_follows_start, start && !busy, LAT, done)
	`TPLS_ASSERT_IMP(a_done_has_start, done, $past(start, LAT))
	`TPLS_ASSERT_IMP(a_singular_zero, done && result.singular,
		(result.point_x == '0) && (result.point_y == '0) && (result.point_z == '0))

endmodule
